/* hdl/hblt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hblt_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int NOW_W           = 48;
  localparam int CNT_W           = 5;
  localparam int IN_TDATA_W      = 88;   // 3+16+16+48 = 83 -> 88
  localparam int OUT_TDATA_W     = 88;   // 2+2+16+16+5+32+5+5+5 = 88
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN = 1'd1;

  localparam logic [2:0] REQ_REGISTER   = 3'd0;
  localparam logic [2:0] REQ_HEARTBEAT  = 3'd1;
  localparam logic [2:0] REQ_DEREGISTER = 3'd2;
  localparam logic [2:0] REQ_SCAN       = 3'd3;
  localparam logic [2:0] REQ_STATS      = 3'd4;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_DEAD    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_STATS   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture request
    logic clr_walk;   // restart slot walk
    logic step;       // examine current slot, advance
    logic do_reg;     // write free slot
    logic do_beat;    // refresh found slot
    logic do_dereg;   // free found slot
  } hblt_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       walk_done;  // last slot examined
    logic       found;
    logic       has_free;
    logic       evict_now;  // current slot is evicted by scan
  } hblt_stat_t;

endpackage
`default_nettype wire

/* hdl/hblt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module hblt_datapath #(
  parameter int NUM_ENTRIES = 16,
  parameter int TIME_BITS   = 48
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire hblt_pkg::hblt_cmd_t cmd,
  output hblt_pkg::hblt_stat_t  stat,
  input  wire [2:0]             in_req,
  input  wire [15:0]            in_svc,
  input  wire [15:0]            in_evt,
  input  wire [47:0]            in_now,
  input  wire [31:0]            dead_to,
  input  wire [31:0]            warn_to,
  output logic [2:0]            req,
  output logic [15:0]           cur_svc,
  output logic [15:0]           cur_evt,
  output logic [4:0]            evicted,
  output logic [31:0]           total,
  output logic [4:0]            act_cnt,
  output logic [4:0]            alv_cnt,
  output logic [4:0]            wrn_cnt
);
  import hblt_pkg::*;
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [NUM_ENTRIES-1:0] act, wrn;
  logic [15:0]            svc_r [NUM_ENTRIES];
  logic [15:0]            evt_r [NUM_ENTRIES];
  logic [TIME_BITS-1:0]   beat_r [NUM_ENTRIES];
  logic [15:0]            k_svc, k_evt;
  logic [TIME_BITS-1:0]   now;
  logic [CW-1:0]          idx;
  logic [IW-1:0]          ci;
  logic [IW-1:0]          fnd_idx, free_idx;
  logic                   found, has_free;
  logic [CW-1:0]          ev_c, a_c, w_c, l_c;
  logic [TIME_BITS-1:0]   age;
  logic                   match, is_dead, is_warn, ahead;

  localparam logic [CW-1:0] LAST = CW'(NUM_ENTRIES - 1);

  assign ci      = idx[IW-1:0];
  assign match   = act[ci] && svc_r[ci] == k_svc && evt_r[ci] == k_evt;
  assign ahead   = now < beat_r[ci];
  assign age     = now - beat_r[ci];
  assign is_dead = act[ci] && !ahead && (CMP_W'(age) > CMP_W'(dead_to));
  assign is_warn = act[ci] && !ahead && (CMP_W'(age) > CMP_W'(warn_to));

  assign stat.walk_done = (idx == LAST);
  assign stat.found     = found;
  assign stat.has_free  = has_free;
  assign stat.evict_now = (req == REQ_SCAN) && is_dead;

  assign cur_svc = svc_r[ci];
  assign cur_evt = evt_r[ci];
  assign evicted = CNT_W'(ev_c);
  assign act_cnt = CNT_W'(a_c);
  assign alv_cnt = CNT_W'(l_c);
  assign wrn_cnt = CNT_W'(w_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      act   <= '0;
      wrn   <= '0;
      total <= '0;
      req   <= '0;
      idx   <= '0;
      found <= 1'b0;
      has_free <= 1'b0;
    end else begin
      if (cmd.load) begin
        req   <= in_req;
        k_svc <= in_svc;
        k_evt <= in_evt;
        now   <= TIME_BITS'(in_now);
      end
      if (cmd.clr_walk) begin
        idx <= '0; found <= 1'b0; has_free <= 1'b0;
        ev_c <= '0; a_c <= '0; w_c <= '0; l_c <= '0;
        fnd_idx <= '0; free_idx <= '0;
      end else if (cmd.step) begin
        if (!stat.walk_done) idx <= idx + 1'b1;
        // search: first match, lowest free slot
        if (match && !found) begin found <= 1'b1; fnd_idx <= ci; end
        if (!act[ci] && !has_free) begin has_free <= 1'b1; free_idx <= ci; end
        if (act[ci]) begin
          a_c <= a_c + 1'b1;
          if (wrn[ci]) w_c <= w_c + 1'b1; else l_c <= l_c + 1'b1;
        end
        if (req == REQ_SCAN) begin
          if (is_dead) begin
            act[ci] <= 1'b0; wrn[ci] <= 1'b0;
            ev_c <= ev_c + 1'b1; total <= total + 1'b1;
          end else if (is_warn) wrn[ci] <= 1'b1;
        end
      end
      if (cmd.do_reg) begin
        act[free_idx] <= 1'b1; wrn[free_idx] <= 1'b0;
        svc_r[free_idx] <= k_svc; evt_r[free_idx] <= k_evt;
        beat_r[free_idx] <= now;
      end
      if (cmd.do_beat) begin
        beat_r[fnd_idx] <= now; wrn[fnd_idx] <= 1'b0;
      end
      if (cmd.do_dereg) begin
        act[fnd_idx] <= 1'b0; wrn[fnd_idx] <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/hblt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module hblt_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [2:0]              in_req,
  input  wire [2:0]              req,
  output hblt_pkg::hblt_cmd_t    cmd,
  input  wire hblt_pkg::hblt_stat_t stat,
  input  wire [15:0]             cur_svc,
  input  wire [15:0]             cur_evt,
  input  wire [4:0]              evicted,
  input  wire [31:0]             total,
  input  wire [4:0]              act_cnt,
  input  wire [4:0]              alv_cnt,
  input  wire [4:0]              wrn_cnt,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [88:0]            out_data
);
  import hblt_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_WALK, S_DEAD, S_FIN, S_OUT} state_t;
  state_t state;
  logic   ok_in;

  function automatic logic [88:0] pack(logic [1:0] k, logic [1:0] s, logic [15:0] ds,
      logic [15:0] de, logic [4:0] ec, logic [31:0] et, logic [4:0] ac,
      logic [4:0] al, logic [4:0] wr, logic l);
    pack = {l, wr, al, ac, et, ec, de, ds, s, k};
  endfunction

  assign ok_in    = in_req <= REQ_STATS;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.clr_walk = cmd.load;
    // the evicted slot is retired once its dead notice is taken
    cmd.step     = ((state == S_WALK) && !stat.evict_now) ||
                   ((state == S_DEAD) && out_ready);
    cmd.do_reg   = (state == S_FIN) && req == REQ_REGISTER && !stat.found && stat.has_free;
    cmd.do_beat  = (state == S_FIN) && req == REQ_HEARTBEAT && stat.found;
    cmd.do_dereg = (state == S_FIN) && req == REQ_DEREGISTER && stat.found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid && ok_in) state <= S_WALK;
        S_WALK: begin
          if (stat.evict_now) begin
            // hold the slot, emit its dead notice first
            out_valid <= 1'b1;
            out_data  <= pack(KIND_DEAD, ST_OK, cur_svc, cur_evt, '0, '0, '0, '0, '0, 1'b0);
            state     <= S_DEAD;
          end else if (stat.walk_done) state <= S_FIN;
        end
        S_DEAD: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_WALK;
        end
        S_FIN: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
          case (req)
            REQ_REGISTER: out_data <= pack(KIND_STATUS, stat.found ? ST_DUP :
                (stat.has_free ? ST_OK : ST_FULL), '0, '0, '0, '0, '0, '0, '0, 1'b1);
            REQ_HEARTBEAT, REQ_DEREGISTER: out_data <= pack(KIND_STATUS,
                stat.found ? ST_OK : ST_NOTFND, '0, '0, '0, '0, '0, '0, '0, 1'b1);
            REQ_SCAN: out_data <= pack(KIND_SUMMARY, ST_OK, '0, '0, evicted, total,
                '0, '0, '0, 1'b1);
            default: out_data <= pack(KIND_STATS, ST_OK, '0, '0, '0, total,
                act_cnt, alv_cnt, wrn_cnt, 1'b1);
          endcase
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/heartbeat_liveness_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  | dir | fields
// s_axis   | in  | tdata: req_type[2:0] service_id[18:3] event_id[34:19] now_ms[82:35]
// m_axis   | out | tdata: kind,status,dead_service,dead_event,evicted_count,
//          |     |        evicted_total,active,alive,warning; tlast: last_flag
// cfg      | in  | idx 0 dead_timeout_ms, idx 1 warn_after_ms
// Each known request walks all NUM_ENTRIES slots, one per cycle except while
// a dead notice waits for the output handshake; unknown requests are dropped.
// rst (synchronous) clears the table's valid bits and counters and restores
// the timeouts to 3000 and 1000.
// A stalled master side holds the walk; input is taken only when idle.
module heartbeat_liveness_table #(
  parameter int NUM_ENTRIES = hblt_pkg::NUM_ENTRIES_DEF,
  parameter int TIME_BITS   = hblt_pkg::TIME_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [87:0]  s_axis_tdata,  // req_type, service_id, event_id, now_ms
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [87:0] m_axis_tdata,  // kind,status,dsvc,devt,ecount,etotal,act,alv,wrn
  output logic        m_axis_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [0:0]   cfg_index,
  input  wire [31:0]  cfg_data
);
  import hblt_pkg::*;

  hblt_cmd_t  cmd;
  hblt_stat_t stat;
  logic [31:0] dead_to, warn_to, total;
  logic [2:0]  req;
  logic [15:0] cur_svc, cur_evt;
  logic [4:0]  evicted, act_cnt, alv_cnt, wrn_cnt;
  logic [88:0] out_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_to <= 32'd3000;
      warn_to <= 32'd1000;
    end else if (cfg_valid) begin
      // hold register, overwrite only the addressed one
      if (cfg_index == CFG_DEAD) dead_to <= cfg_data;
      else warn_to <= cfg_data;
    end
  end

  hblt_datapath #(.NUM_ENTRIES(NUM_ENTRIES), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_req(s_axis_tdata[2:0]), .in_svc(s_axis_tdata[18:3]),
    .in_evt(s_axis_tdata[34:19]), .in_now(s_axis_tdata[82:35]),
    .dead_to, .warn_to, .req, .cur_svc, .cur_evt, .evicted, .total,
    .act_cnt, .alv_cnt, .wrn_cnt);

  hblt_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(s_axis_tdata[2:0]), .req, .cmd, .stat, .cur_svc, .cur_evt,
    .evicted, .total, .act_cnt, .alv_cnt, .wrn_cnt,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data);

  assign m_axis_tdata = out_data[87:0];
  assign m_axis_tlast = out_data[88];
endmodule
`default_nettype wire

/* bench/heartbeat_liveness_table_tb.sv */
`timescale 1ns / 1ps
module heartbeat_liveness_table_tb;
  import hblt_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  // one request as it travels on the slave side
  typedef struct packed {
    logic [47:0] now_ms;
    logic [15:0] event_id;
    logic [15:0] service_id;
    logic [2:0]  req_type;
  } request_t;

  // one reply as the block reports it
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] dead_service;
    logic [15:0] dead_event;
    logic [4:0]  evicted_count;
    logic [31:0] evicted_total;
    logic [4:0]  active_count;
    logic [4:0]  alive_count;
    logic [4:0]  warning_count;
    logic        last;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  heartbeat_liveness_table uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the subscriber table
  logic        tbl_used [SLOTS];
  logic [15:0] tbl_svc [SLOTS];
  logic [15:0] tbl_evt [SLOTS];
  logic [47:0] tbl_beat [SLOTS];
  logic        tbl_warn [SLOTS];
  logic [31:0] evict_sum;
  logic [31:0] dead_limit;
  logic [31:0] warn_limit;

  request_t pending_requests[$];
  reply_t   expected_replies[$];

  int  send_idle_pct = 0;   // percent of cycles the sender sits idle
  int  recv_stall_pct = 0;  // percent of cycles the receiver stalls
  int  hold_off_cycles = 0; // long receiver hold-off, counted down on its own
  int  errors = 0;
  int  requests_sent = 0;
  int  replies_seen = 0;
  int  evictions_seen = 0;
  int  quiet_cycles = 0;

  // handshake flag latched at the rising edge for the driver
  logic s_axis_tready_q = 1'b0;

  function automatic reply_t blank_reply(logic [1:0] kind);
    reply_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int lookup_key(logic [15:0] svc, logic [15:0] evt);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_used[i] && tbl_svc[i] == svc && tbl_evt[i] == evt) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and queue the replies it causes.
  function automatic void predict_liveness(request_t rq);
    reply_t r;
    int     idx;
    logic [47:0] age;
    logic [4:0]  n_evict;
    logic [4:0]  n_act, n_alv, n_wrn;
    r = blank_reply(KIND_STATUS);
    case (rq.req_type)
      REQ_REGISTER: begin
        idx = -1;
        if (lookup_key(rq.service_id, rq.event_id) >= 0) begin
          r.status = ST_DUP;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_used[i] && idx < 0) idx = i;
          if (idx < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_used[idx] = 1'b1;
            tbl_svc[idx] = rq.service_id;
            tbl_evt[idx] = rq.event_id;
            tbl_beat[idx] = rq.now_ms;
            tbl_warn[idx] = 1'b0;
            r.status = ST_OK;
          end
        end
        expected_replies.push_back(r);
      end
      REQ_HEARTBEAT, REQ_DEREGISTER: begin
        idx = lookup_key(rq.service_id, rq.event_id);
        if (idx < 0) begin
          r.status = ST_NOTFND;
        end else begin
          r.status = ST_OK;
          tbl_warn[idx] = 1'b0;
          if (rq.req_type == REQ_HEARTBEAT) tbl_beat[idx] = rq.now_ms;
          else tbl_used[idx] = 1'b0;
        end
        expected_replies.push_back(r);
      end
      REQ_SCAN: begin
        n_evict = '0;
        for (int i = 0; i < SLOTS; i++) begin
          // skip unused entries and entries whose beat lies in the future
          if (tbl_used[i] && rq.now_ms >= tbl_beat[i]) begin
            age = rq.now_ms - tbl_beat[i];
            if (age > {16'd0, dead_limit}) begin
              tbl_used[i] = 1'b0;
              tbl_warn[i] = 1'b0;
              r = blank_reply(KIND_DEAD);
              r.last = 1'b0;
              r.dead_service = tbl_svc[i];
              r.dead_event = tbl_evt[i];
              expected_replies.push_back(r);
              evict_sum++;
              n_evict++;
            end else if (age > {16'd0, warn_limit}) begin
              tbl_warn[i] = 1'b1;
            end
          end
        end
        r = blank_reply(KIND_SUMMARY);
        r.evicted_count = n_evict;
        r.evicted_total = evict_sum;
        expected_replies.push_back(r);
      end
      REQ_STATS: begin
        n_act = '0; n_alv = '0; n_wrn = '0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_used[i]) begin
            n_act++;
            if (tbl_warn[i]) n_wrn++;
            else n_alv++;
          end
        r = blank_reply(KIND_STATS);
        r.evicted_total = evict_sum;
        r.active_count = n_act;
        r.alive_count = n_alv;
        r.warning_count = n_wrn;
        expected_replies.push_back(r);
      end
      default: ; // unknown request: no reply, no change
    endcase
  endfunction

  // Driver: present requests at the falling edge, advance on handshake.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          s_axis_tdata <= {5'd0, pending_requests.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (hold_off_cycles > 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Handshake sampling at the rising edge; the driver reads the latched flag.
  always @(posedge clk) begin
    s_axis_tready_q <= s_axis_tready && s_axis_tvalid && !rst;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_liveness(request_t'(s_axis_tdata[82:0]));
      requests_sent++;
    end
  end

  // Long receiver hold-off, counted down once per cycle.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor: compare each reply with the oldest expectation.
  always @(posedge clk) begin
    reply_t got, want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[1:0];
      got.status = m_axis_tdata[3:2];
      got.dead_service = m_axis_tdata[19:4];
      got.dead_event = m_axis_tdata[35:20];
      got.evicted_count = m_axis_tdata[40:36];
      got.evicted_total = m_axis_tdata[72:41];
      got.active_count = m_axis_tdata[77:73];
      got.alive_count = m_axis_tdata[82:78];
      got.warning_count = m_axis_tdata[87:83];
      got.last = m_axis_tlast;
      replies_seen++;
      if (got.kind == KIND_DEAD) evictions_seen++;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply kind=%0d", got.kind);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d got %0d", want.kind, got.kind); errors++;
        end
        if (got.status != want.status) begin
          $error("status: expected %0d got %0d", want.status, got.status); errors++;
        end
        if (got.dead_service != want.dead_service) begin
          $error("dead_service: expected %h got %h", want.dead_service,
                 got.dead_service); errors++;
        end
        if (got.dead_event != want.dead_event) begin
          $error("dead_event: expected %h got %h", want.dead_event, got.dead_event);
          errors++;
        end
        if (got.evicted_count != want.evicted_count) begin
          $error("evicted_count: expected %0d got %0d", want.evicted_count,
                 got.evicted_count); errors++;
        end
        if (got.evicted_total != want.evicted_total) begin
          $error("evicted_total: expected %0d got %0d", want.evicted_total,
                 got.evicted_total); errors++;
        end
        if (got.active_count != want.active_count) begin
          $error("active_count: expected %0d got %0d", want.active_count,
                 got.active_count); errors++;
        end
        if (got.alive_count != want.alive_count) begin
          $error("alive_count: expected %0d got %0d", want.alive_count,
                 got.alive_count); errors++;
        end
        if (got.warning_count != want.warning_count) begin
          $error("warning_count: expected %0d got %0d", want.warning_count,
                 got.warning_count); errors++;
        end
        if (got.last != want.last) begin
          $error("last_flag: expected %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d replies outstanding", expected_replies.size());
      $display("heartbeat_liveness_table verification failed");
      $finish;
    end
  end

  // Keys come from a small pool so that duplicates, hits and a full table occur.
  logic [15:0] key_svc [24];
  logic [15:0] key_evt [24];
  logic [47:0] clock_ms;

  function automatic request_t make_request(logic [2:0] kind, int key, logic [47:0] t);
    request_t rq;
    rq.req_type = kind;
    rq.service_id = key_svc[key];
    rq.event_id = key_evt[key];
    rq.now_ms = t;
    return rq;
  endfunction

  // Write one register at a falling edge and wait for the handshake.
  task automatic write_register(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEAD) dead_limit = value;
    else warn_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until the queue is drained and every reply has come back.
  task automatic drain_requests();
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One phase of random traffic, mostly well-formed register/beat/deregister/scan/stats requests.
  task automatic random_phase(int count, int idle, int stall);
    int sel, key;
    logic [2:0] kind;
    logic [82:0] raw;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99, 0);
      key = $urandom_range(23, 0);
      // advance time by a spread that crosses the warning and dead limits
      case ($urandom_range(3, 0))
        0: clock_ms += $urandom_range(50, 0);
        1: clock_ms += $urandom_range(2000, 0);
        2: clock_ms += {16'd0, warn_limit} + $urandom_range(3, 0) - 2;
        default: clock_ms += {16'd0, dead_limit} + $urandom_range(3, 0) - 2;
      endcase
      if (sel < 30) kind = REQ_REGISTER;
      else if (sel < 55) kind = REQ_HEARTBEAT;
      else if (sel < 65) kind = REQ_DEREGISTER;
      else if (sel < 85) kind = REQ_SCAN;
      else if (sel < 95) kind = REQ_STATS;
      else kind = 3'($urandom_range(7, 5));
      if (sel >= 95 || $urandom_range(19, 0) == 0) begin
        raw = 83'({$urandom, $urandom, $urandom});
        raw[2:0] = kind;
        pending_requests.push_back(request_t'(raw));
      end else if (kind == REQ_SCAN && $urandom_range(9, 0) == 0)
        // an old timestamp leaves newer beats ahead of now
        pending_requests.push_back(make_request(kind, key, clock_ms - $urandom_range(500, 0)));
      else
        pending_requests.push_back(make_request(kind, key, clock_ms));
    end
    drain_requests();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_warn[i] = 1'b0;
      tbl_svc[i] = '0;
      tbl_evt[i] = '0;
      tbl_beat[i] = '0;
    end
    evict_sum = '0;
    dead_limit = 32'd3000;
    warn_limit = 32'd1000;
    key_svc[0] = 16'h0000; key_evt[0] = 16'h0000;
    key_svc[1] = 16'hFFFF; key_evt[1] = 16'hFFFF;
    for (int i = 2; i < 24; i++) begin
      key_svc[i] = 16'($urandom);
      key_evt[i] = (i % 3 == 0) ? key_evt[i - 1] : 16'($urandom);
    end
    clock_ms = 48'd5000;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: fill the table past capacity, duplicate, miss, scans across limits.
    for (int k = 0; k < 17; k++)
      pending_requests.push_back(make_request(REQ_REGISTER, k, 48'd1000 + k * 100));
    pending_requests.push_back(make_request(REQ_REGISTER, 0, 48'd2000));
    pending_requests.push_back(make_request(REQ_HEARTBEAT, 20, 48'd2000));
    pending_requests.push_back(make_request(REQ_DEREGISTER, 21, 48'd2000));
    pending_requests.push_back(make_request(REQ_HEARTBEAT, 3, 48'hFFFF_FFFF_FFFF));
    pending_requests.push_back(make_request(REQ_SCAN, 0, 48'd3050));
    pending_requests.push_back(make_request(REQ_STATS, 0, 48'd0));
    pending_requests.push_back(make_request(3'd7, 0, 48'd0));
    pending_requests.push_back(make_request(REQ_SCAN, 0, 48'd5000));
    pending_requests.push_back(make_request(REQ_DEREGISTER, 3, 48'd0));
    pending_requests.push_back(make_request(REQ_STATS, 0, 48'd0));
    drain_requests();

    // Let the replies back up so the block stalls its input.
    hold_off_cycles = 400;
    random_phase(40, 0, 0);

    write_register(CFG_DEAD, 32'd1);
    write_register(CFG_WARN, 32'd1);
    random_phase(60, 0, 0);
    write_register(CFG_DEAD, 32'hFFFF_FFFF);
    write_register(CFG_WARN, 32'hFFFF_FFFF);
    clock_ms = 48'hFFFE_0000_0000;
    random_phase(40, 82, 0);
    write_register(CFG_DEAD, 32'd3000);
    write_register(CFG_WARN, 32'd1000);
    random_phase(120, 0, 82);
    write_register(CFG_DEAD, 32'd500);
    write_register(CFG_WARN, 32'd200);
    random_phase(80, 13, 13);
    random_phase(110, 0, 0);

    $display("covered %0d requests, %0d replies, %0d dead notices, limits from 1 to max",
             requests_sent, replies_seen, evictions_seen);
    if (errors == 0) begin
      $display("heartbeat_liveness_table verification clean");
    end else begin
      $display("heartbeat_liveness_table verification failed");
    end
    $finish;
  end

endmodule
